>>> rtl/core/height_from_gradient_relaxation_macros.svh
// Assertion macros shared by the RTL of the relaxation block.
`ifndef HEIGHT_FROM_GRADIENT_RELAXATION_MACROS_SVH
`define HEIGHT_FROM_GRADIENT_RELAXATION_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define HFG_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("relaxation block: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define HFG_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("relaxation block: next-cycle check failed");

`endif

>>> rtl/core/hfg_pkg.sv
`timescale 1ns / 1ps

package hfg_pkg;

  // Request codes on the input channel.
  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_RUN  = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  // Result kinds.
  localparam logic RES_READ = 1'b0;
  localparam logic RES_DONE = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_SWEEPS = 2'd2;

  typedef logic signed [31:0] word_t;
  typedef logic signed [34:0] acc_t;

endpackage

>>> rtl/core/hfg_ram.sv
`timescale 1ns / 1ps

module hfg_ram #(
  parameter int ADDR_W = 16,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [0:(1<<ADDR_W)-1];
  logic [DATA_W-1:0] rd_data_r;

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/core/height_from_gradient_relaxation.sv
`timescale 1ns / 1ps
// Height from gradient by Jacobi relaxation with wrap-around edges.
// Requests arrive on the in_ channel (valid/stall): load a pixel, run the
// relaxation, or read a height. Results leave on the out_ channel.
// A load gives no result; it is taken even while a result waits on the
// output.
// A read reads the height store at the request and loads the result
// register in the cycle after it.
// A run does N sweeps, where N is the sweep count rounded up to odd;
// when the width or height is one, the estimate is cleared first. The
// four neighbours of each pixel are read one after another (left, right,
// up, down) from a single read port on each store before its new height
// is written. One done result follows.
// A request that gives a result is stalled while an earlier result waits.
// While the receiver stalls, the result register holds its contents.
// Reset (synchronous, rst_n low) clears control state and the output valid
// and restores the register defaults; store contents stay undefined until
// loaded.
module height_from_gradient_relaxation
  import hfg_pkg::*;
#(
  parameter int MAX_DIM = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_pixel_index,
  input  word_t       in_grad_x,
  input  word_t       in_grad_y,
  input  word_t       in_height_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_result_kind,
  output logic [15:0] out_index_out,
  output word_t       out_height_out,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  `include "height_from_gradient_relaxation_macros.svh"

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_CLEAR = 3'd2;
  localparam logic [2:0] ST_SWEEP = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;

  localparam logic [2:0] PH_LEFT  = 3'd0;
  localparam logic [2:0] PH_RIGHT = 3'd1;
  localparam logic [2:0] PH_UP    = 3'd2;
  localparam logic [2:0] PH_DOWN  = 3'd3;
  localparam logic [2:0] PH_WRITE = 3'd4;

  // Configuration registers.
  logic [8:0]  cfg_width_r, cfg_height_r;
  logic [19:0] cfg_sweeps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= 9'd256;
      cfg_height_r <= 9'd256;
      cfg_sweeps_r <= 20'd512;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_WIDTH:  cfg_width_r  <= cfg_data[8:0];
        CFG_HEIGHT: cfg_height_r <= cfg_data[8:0];
        CFG_SWEEPS: cfg_sweeps_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Dimensions in use, clamped to one at the bottom and MAX_DIM at the top.
  logic [DIM_W-1:0] w_use, h_use;

  always_comb begin
    if (cfg_width_r == 9'd0) begin
      w_use = DIM_W'(1);
    end else if (32'(cfg_width_r) > 32'(MAX_DIM)) begin
      w_use = DIM_W'(MAX_DIM);
    end else begin
      w_use = DIM_W'(cfg_width_r);
    end
    if (cfg_height_r == 9'd0) begin
      h_use = DIM_W'(1);
    end else if (32'(cfg_height_r) > 32'(MAX_DIM)) begin
      h_use = DIM_W'(MAX_DIM);
    end else begin
      h_use = DIM_W'(cfg_height_r);
    end
  end

  // Control state.
  logic [2:0]        state_r, state_nxt;
  logic [2:0]        phase_r;
  logic              result_in_b_r;
  logic              out_valid_r;
  logic              out_kind_r;
  logic [15:0]       out_index_r;
  word_t             out_height_r;
  logic              rd_in_range_r;
  logic [DIM_W-1:0]  w_r, h_r, row_r, col_r;
  logic [ADDR_W-1:0] rb_r, ub_r, db_r, ub_init_r;
  logic [CNT_W-1:0]  total_r, clr_cnt_r;
  logic [19:0]       sweep_r, sweep_last_r;
  acc_t              acc_r;

  logic in_accept, out_accept, in_range;
  logic [ADDR_W-1:0] in_addr;

  assign in_range  = 32'(in_pixel_index) < 32'(DEPTH);
  assign in_addr   = ADDR_W'(in_pixel_index);
  assign in_stall  = (state_r != ST_IDLE) ||
                     (out_valid_r && ((in_action == ACT_RUN) || (in_action == ACT_READ)));
  assign in_accept = in_valid && !in_stall;
  assign out_accept = out_valid_r && !out_stall;

  // Neighbour columns and addresses of the current pixel.
  logic [DIM_W-1:0]  col_lf, col_rt;
  logic [ADDR_W-1:0] nb_addr, cur_addr;
  logic              last_col, last_row, last_sweep;

  assign last_col   = col_r == w_r - DIM_W'(1);
  assign last_row   = row_r == h_r - DIM_W'(1);
  assign last_sweep = sweep_r == sweep_last_r;
  assign col_lf     = (col_r == '0) ? w_r - DIM_W'(1) : col_r - DIM_W'(1);
  assign col_rt     = last_col ? '0 : col_r + DIM_W'(1);
  assign cur_addr   = rb_r + ADDR_W'(col_r);

  always_comb begin
    case (phase_r)
      PH_LEFT:  nb_addr = rb_r + ADDR_W'(col_lf);
      PH_RIGHT: nb_addr = rb_r + ADDR_W'(col_rt);
      PH_UP:    nb_addr = ub_r + ADDR_W'(col_r);
      PH_DOWN:  nb_addr = db_r + ADDR_W'(col_r);
      default:  nb_addr = cur_addr;
    endcase
  end

  // Store ports.
  logic [ADDR_W-1:0] rd_addr;
  word_t gx_rd, gy_rd, ha_rd, hb_rd;
  logic              ha_we, hb_we, grad_we;
  logic [ADDR_W-1:0] ha_waddr;
  word_t             ha_wdata, new_h;

  assign rd_addr  = (state_r == ST_SWEEP) ? nb_addr : in_addr;
  assign grad_we  = in_accept && (in_action == ACT_LOAD) && in_range;
  assign ha_we    = grad_we || (state_r == ST_CLEAR) ||
                    ((state_r == ST_SWEEP) && (phase_r == PH_WRITE) && sweep_r[0]);
  assign hb_we    = (state_r == ST_SWEEP) && (phase_r == PH_WRITE) && !sweep_r[0];

  always_comb begin
    if (state_r == ST_CLEAR) begin
      ha_waddr = ADDR_W'(clr_cnt_r);
      ha_wdata = '0;
    end else if (state_r == ST_SWEEP) begin
      ha_waddr = cur_addr;
      ha_wdata = new_h;
    end else begin
      ha_waddr = in_addr;
      ha_wdata = in_height_in;
    end
  end

  hfg_ram #(.ADDR_W(ADDR_W), .DATA_W(32)) u_gx (
    .clk(clk), .wr_en(grad_we), .wr_addr(in_addr), .wr_data(in_grad_x),
    .rd_addr(rd_addr), .rd_data(gx_rd)
  );
  hfg_ram #(.ADDR_W(ADDR_W), .DATA_W(32)) u_gy (
    .clk(clk), .wr_en(grad_we), .wr_addr(in_addr), .wr_data(in_grad_y),
    .rd_addr(rd_addr), .rd_data(gy_rd)
  );
  hfg_ram #(.ADDR_W(ADDR_W), .DATA_W(32)) u_ha (
    .clk(clk), .wr_en(ha_we), .wr_addr(ha_waddr), .wr_data(ha_wdata),
    .rd_addr(rd_addr), .rd_data(ha_rd)
  );
  hfg_ram #(.ADDR_W(ADDR_W), .DATA_W(32)) u_hb (
    .clk(clk), .wr_en(hb_we), .wr_addr(cur_addr), .wr_data(new_h),
    .rd_addr(rd_addr), .rd_data(hb_rd)
  );

  // Neighbour term: source height plus or minus the matching gradient.
  word_t src_h;
  acc_t  term, sum;
  logic signed [32:0] quarter;

  assign src_h = sweep_r[0] ? hb_rd : ha_rd;

  always_comb begin
    case (phase_r)
      PH_RIGHT: term = acc_t'(src_h) + acc_t'(gx_rd);
      PH_UP:    term = acc_t'(src_h) - acc_t'(gx_rd);
      PH_DOWN:  term = acc_t'(src_h) + acc_t'(gy_rd);
      PH_WRITE: term = acc_t'(src_h) - acc_t'(gy_rd);
      default:  term = '0;
    endcase
  end

  // Rounded quarter of the four terms, saturated to 32 bits.
  assign sum     = acc_r + term;
  assign quarter = 33'((sum + acc_t'(2)) >>> 2);

  always_comb begin
    if (quarter > 33'sh0_7FFF_FFFF) begin
      new_h = 32'sh7FFF_FFFF;
    end else if (quarter < -33'sh0_8000_0000) begin
      new_h = 32'sh8000_0000;
    end else begin
      new_h = quarter[31:0];
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept && (in_action == ACT_RUN)) begin
          state_nxt = ST_SETUP;
        end else if (in_accept && (in_action == ACT_READ)) begin
          state_nxt = ST_READ;
        end
      end
      ST_SETUP: begin
        state_nxt = ((w_r == DIM_W'(1)) || (h_r == DIM_W'(1))) ? ST_CLEAR : ST_SWEEP;
      end
      ST_CLEAR: begin
        if (clr_cnt_r == total_r - CNT_W'(1)) begin
          state_nxt = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if ((phase_r == PH_WRITE) && last_col && last_row && last_sweep) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_READ:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      phase_r       <= PH_LEFT;
      result_in_b_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_accept) begin
        out_valid_r <= 1'b0;
      end
      if (in_accept && (in_action == ACT_LOAD)) begin
        result_in_b_r <= 1'b0;
      end
      if (state_r == ST_READ) begin
        out_valid_r <= 1'b1;
      end
      if (state_r == ST_SWEEP) begin
        phase_r <= (phase_r == PH_WRITE) ? PH_LEFT : phase_r + 3'd1;
        if ((phase_r == PH_WRITE) && last_col && last_row && last_sweep) begin
          result_in_b_r <= 1'b1;
          out_valid_r   <= 1'b1;
        end
      end else begin
        phase_r <= PH_LEFT;
      end
    end
  end

  // Run set-up, raster walk and accumulation.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      w_r           <= w_use;
      h_r           <= h_use;
      // The sweep count is rounded up to odd, so the last sweep index is even.
      sweep_last_r  <= {cfg_sweeps_r[19:1], 1'b0};
      rd_in_range_r <= in_range;
    end
    // Only requests that give a result touch the waiting result fields.
    if (in_accept && ((in_action == ACT_READ) || (in_action == ACT_RUN))) begin
      out_index_r   <= (in_action == ACT_READ) ? in_pixel_index : 16'd0;
      out_kind_r    <= (in_action == ACT_READ) ? RES_READ : RES_DONE;
    end
    case (state_r)
      ST_SETUP: begin
        total_r   <= CNT_W'(w_r) * CNT_W'(h_r);
        ub_init_r <= ADDR_W'(h_r - DIM_W'(1)) * ADDR_W'(w_r);
        ub_r      <= ADDR_W'(h_r - DIM_W'(1)) * ADDR_W'(w_r);
        rb_r      <= '0;
        db_r      <= (h_r == DIM_W'(1)) ? '0 : ADDR_W'(w_r);
        row_r     <= '0;
        col_r     <= '0;
        sweep_r   <= '0;
        clr_cnt_r <= '0;
      end
      ST_CLEAR: begin
        clr_cnt_r <= clr_cnt_r + CNT_W'(1);
      end
      ST_SWEEP: begin
        case (phase_r)
          PH_RIGHT: acc_r <= term;
          PH_UP:    acc_r <= sum;
          PH_DOWN:  acc_r <= sum;
          PH_WRITE: begin
            if (!last_col) begin
              col_r <= col_r + DIM_W'(1);
            end else begin
              col_r <= '0;
              if (last_row) begin
                row_r   <= '0;
                rb_r    <= '0;
                ub_r    <= ub_init_r;
                db_r    <= (h_r == DIM_W'(1)) ? '0 : ADDR_W'(w_r);
                sweep_r <= sweep_r + 20'd1;
              end else begin
                row_r <= row_r + DIM_W'(1);
                ub_r  <= rb_r;
                rb_r  <= db_r;
                db_r  <= (row_r + DIM_W'(1) == h_r - DIM_W'(1)) ? '0 : db_r + ADDR_W'(w_r);
              end
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    if (state_r == ST_READ) begin
      out_height_r <= !rd_in_range_r ? '0 : (result_in_b_r ? hb_rd : ha_rd);
    end else if ((state_r == ST_SWEEP) && (phase_r == PH_WRITE)) begin
      out_height_r <= '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_index_out   = out_index_r;
  assign out_height_out  = out_height_r;

  // Only one height buffer is written in a cycle.
  `HFG_ASSERT_IMP(a_one_buffer_write, ha_we && (state_r == ST_SWEEP), !hb_we)
  // Requests are only taken by an idle sequencer.
  `HFG_ASSERT_IMP(a_accept_idle, in_accept, state_r == ST_IDLE)
  // A run request starts the set-up step.
  `HFG_ASSERT_NXT(a_run_setup, in_accept && (in_action == ACT_RUN), state_r == ST_SETUP)
  // A finished run leaves its result pointing at buffer b.
  `HFG_ASSERT_NXT(a_done_in_b, (state_r == ST_SWEEP) && (state_nxt == ST_IDLE),
                  result_in_b_r && out_valid_r)

endmodule

>>> tb/sv/height_checker.sv
`timescale 1ns / 1ps

module height_checker
  import hfg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_pixel_index,
  input  word_t       in_grad_x,
  input  word_t       in_grad_y,
  input  word_t       in_height_in,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_result_kind,
  input  logic [15:0] out_index_out,
  input  word_t       out_height_out,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data,
  output int          mismatches,
  output int          outstanding
);

  localparam int DEPTH = 65536;

  typedef struct packed {
    logic        kind;
    logic [15:0] pixel;
    word_t       height;
  } height_result_t;

  height_result_t awaited_results[$];

  // Own copy of the block's stores and registers.
  word_t       grad_x_mem [DEPTH];
  word_t       grad_y_mem [DEPTH];
  word_t       height_a   [DEPTH];
  word_t       height_b   [DEPTH];
  logic        heights_in_b;
  logic [8:0]  width_reg;
  logic [8:0]  height_reg;
  logic [19:0] sweeps_reg;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic int dim_used(logic [8:0] v);
    if (v == 0) return 1;
    if (v > 256) return 256;
    return int'(v);
  endfunction

  // Quarter of the sum, rounded half up, saturated to 32 bits.
  function automatic word_t quarter_sat(longint s);
    longint q;
    q = (s + 2) >>> 2;
    if (q > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (q < -64'sd2147483648) return 32'sh80000000;
    return word_t'(q);
  endfunction

  function automatic longint src_height(bit from_a, int i);
    return from_a ? longint'(height_a[i]) : longint'(height_b[i]);
  endfunction

  // One Jacobi sweep with wrap-around edges.
  function automatic void jacobi_sweep(bit from_a, int w, int h);
    int up, dn, lf, rt, il, ir, iu, id;
    longint s;
    for (int r = 0; r < h; r++) begin
      up = (r == 0) ? h - 1 : r - 1;
      dn = (r == h - 1) ? 0 : r + 1;
      for (int c = 0; c < w; c++) begin
        lf = (c == 0) ? w - 1 : c - 1;
        rt = (c == w - 1) ? 0 : c + 1;
        il = r * w + lf;
        ir = r * w + rt;
        iu = up * w + c;
        id = dn * w + c;
        s = src_height(from_a, il) + longint'(grad_x_mem[il])
          + src_height(from_a, ir) - longint'(grad_x_mem[ir])
          + src_height(from_a, iu) + longint'(grad_y_mem[iu])
          + src_height(from_a, id) - longint'(grad_y_mem[id]);
        if (from_a) height_b[r * w + c] = quarter_sat(s);
        else height_a[r * w + c] = quarter_sat(s);
      end
    end
  endfunction

  function automatic void relax_heights();
    int w, h, n;
    w = dim_used(width_reg);
    h = dim_used(height_reg);
    n = int'(sweeps_reg);
    if (n % 2 == 0) n++;
    if (w == 1 || h == 1)
      for (int i = 0; i < w * h; i++) height_a[i] = '0;
    for (int k = 0; k < n; k++) jacobi_sweep(k % 2 == 0, w, h);
    heights_in_b = 1'b1;
  endfunction

  always @(posedge clk) begin
    height_result_t exp_res;
    if (!rst_n) begin
      awaited_results.delete();
      heights_in_b = 1'b0;
      width_reg    = 9'd256;
      height_reg   = 9'd256;
      sweeps_reg   = 20'd512;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_WIDTH:  width_reg  = cfg_data[8:0];
          CFG_HEIGHT: height_reg = cfg_data[8:0];
          CFG_SWEEPS: sweeps_reg = cfg_data;
          default: ;
        endcase
      end

      // Compare an accepted result with the oldest prediction.
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $error("result with no request awaiting it");
          mismatches++;
        end else begin
          exp_res = awaited_results.pop_front();
          if (out_result_kind !== exp_res.kind) begin
            $error("result_kind: expected %0d, actual %0d", exp_res.kind, out_result_kind);
            mismatches++;
          end
          if (out_index_out !== exp_res.pixel) begin
            $error("index_out: expected %0d, actual %0d", exp_res.pixel, out_index_out);
            mismatches++;
          end
          if (out_height_out !== exp_res.height) begin
            $error("height_out: expected %0d, actual %0d", exp_res.height, out_height_out);
            mismatches++;
          end
        end
      end

      // Predict the effect of an accepted request.
      if (in_valid && !in_stall) begin
        case (in_action)
          ACT_LOAD: begin
            grad_x_mem[in_pixel_index] = in_grad_x;
            grad_y_mem[in_pixel_index] = in_grad_y;
            height_a[in_pixel_index]   = in_height_in;
            heights_in_b = 1'b0;
          end
          ACT_RUN: begin
            relax_heights();
            awaited_results.push_back('{RES_DONE, 16'd0, 32'sd0});
          end
          ACT_READ: begin
            exp_res = '{RES_READ, in_pixel_index,
                        heights_in_b ? height_b[in_pixel_index] : height_a[in_pixel_index]};
            awaited_results.push_back(exp_res);
          end
          default: ;
        endcase
      end
    end
    outstanding = awaited_results.size();
  end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import hfg_pkg::*;

  localparam logic [1:0] ACT_IGNORED = 2'd3;
  localparam int DEPTH = 65536;
  localparam int CYCLE_LIMIT = 3000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_action = ACT_LOAD;
  logic [15:0] in_pixel_index = '0;
  word_t       in_grad_x = '0;
  word_t       in_grad_y = '0;
  word_t       in_height_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_result_kind;
  logic [15:0] out_index_out;
  word_t       out_height_out;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = CFG_WIDTH;
  logic [19:0] cfg_data = '0;

  int mismatches;
  int outstanding;

  // Stimulus-side bookkeeping so that no unwritten entry is ever used.
  bit grad_loaded [DEPTH];
  bit a_valid     [DEPTH];
  bit b_valid     [DEPTH];
  bit reads_from_b;
  int img_w = 256;
  int img_h = 256;

  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_go = 1'b0;
  int hold_left = 0;
  int requests_sent = 0;
  int cycles = 0;

  height_from_gradient_relaxation u_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_action, .in_pixel_index,
    .in_grad_x, .in_grad_y, .in_height_in, .out_valid, .out_stall,
    .out_result_kind, .out_index_out, .out_height_out,
    .cfg_wr_en, .cfg_index, .cfg_data
  );

  height_checker u_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_action, .in_pixel_index,
    .in_grad_x, .in_grad_y, .in_height_in, .out_valid, .out_stall,
    .out_result_kind, .out_index_out, .out_height_out,
    .cfg_wr_en, .cfg_index, .cfg_data, .mismatches, .outstanding
  );

  always #5 clk = ~clk;

  // Run guard.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("height_from_gradient_relaxation test failed");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off when asked for one.
  always @(posedge clk) begin
    if (hold_go) begin
      hold_left = 300;
      hold_go = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic word_t rand_word();
    case ($urandom_range(3))
      0: return word_t'($urandom);
      1: return word_t'($signed($urandom_range(0, 32'h3FFFFFF)) - 32'sh2000000);
      2: begin
        case ($urandom_range(3))
          0: return 32'sh7FFFFFFF;
          1: return 32'sh80000000;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      default: return word_t'($signed($urandom_range(0, 32'h7FFFFFFF)) - 32'sh40000000);
    endcase
  endfunction

  function automatic int dim_of(int raw);
    if (raw == 0) return 1;
    if (raw > 256) return 256;
    return raw;
  endfunction

  // Offer one request and wait until it is taken.
  task automatic send(logic [1:0] act, logic [15:0] idx, word_t gx, word_t gy, word_t hv);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= act;
    in_pixel_index <= idx;
    in_grad_x      <= gx;
    in_grad_y      <= gy;
    in_height_in   <= hv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
    case (act)
      ACT_LOAD: begin
        grad_loaded[idx] = 1'b1;
        a_valid[idx] = 1'b1;
        reads_from_b = 1'b0;
      end
      ACT_RUN: begin
        for (int i = 0; i < img_w * img_h; i++) begin
          a_valid[i] = 1'b1;
          b_valid[i] = 1'b1;
        end
        reads_from_b = 1'b1;
      end
      default: ;
    endcase
  endtask

  task automatic load_pixel(int idx);
    send(ACT_LOAD, 16'(idx), rand_word(), rand_word(), rand_word());
  endtask

  // A read goes out only where the selected buffer holds written data.
  task automatic read_pixel(int idx);
    if (reads_from_b ? b_valid[idx] : a_valid[idx])
      send(ACT_READ, 16'(idx), word_t'($urandom), word_t'($urandom), word_t'($urandom));
  endtask

  task automatic send_noise();
    send(ACT_IGNORED, 16'($urandom), word_t'($urandom), word_t'($urandom), word_t'($urandom));
  endtask

  task automatic run_relaxation();
    send(ACT_RUN, 16'($urandom), word_t'($urandom), word_t'($urandom), word_t'($urandom));
  endtask

  // Wait until every result has arrived and the block has gone quiet.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [19:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(int raw_w, int raw_h, int sweeps);
    settle();
    write_reg(CFG_WIDTH, 20'(raw_w));
    write_reg(CFG_HEIGHT, 20'(raw_h));
    write_reg(CFG_SWEEPS, 20'(sweeps));
    img_w = dim_of(raw_w);
    img_h = dim_of(raw_h);
  endtask

  // Load the whole image, with reads of loaded pixels and ignored requests mixed in.
  task automatic load_image();
    for (int i = 0; i < img_w * img_h; i++) begin
      load_pixel(i);
      if ($urandom_range(9) == 0) read_pixel($urandom_range(0, i));
      if ($urandom_range(19) == 0) send_noise();
    end
  endtask

  task automatic read_some(int count);
    for (int i = 0; i < count; i++) read_pixel($urandom_range(0, img_w * img_h - 1));
  endtask

  initial begin
    int n_rounds;
    int phase;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: a 2x2 image with saturating extremes, single sweep.
    configure(2, 2, 0);
    send(ACT_LOAD, 16'd0, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF);
    send(ACT_LOAD, 16'd1, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000);
    send(ACT_LOAD, 16'd2, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    send(ACT_LOAD, 16'd3, 32'sh80000000, 32'sh80000000, 32'sh80000000);
    read_pixel(0);
    send_noise();
    run_relaxation();
    read_some(4);
    // A load at the top index sends reads back to the estimate buffer.
    send(ACT_LOAD, 16'hFFFF, -32'sd1, 32'sd0, 32'sh7FFFFFFF);
    read_pixel(65535);
    read_pixel(1);
    // Width of zero acts as one: degenerate run, three sweeps.
    configure(0, 3, 2);
    load_image();
    run_relaxation();
    read_some(3);
    // Widest row, degenerate, one sweep.
    configure(511, 1, 1);
    load_image();
    run_relaxation();
    read_pixel(0);
    read_pixel(255);
    // Single pixel with many sweeps.
    configure(1, 1, 1001);
    load_pixel(0);
    run_relaxation();
    read_pixel(0);

    // Random phases cycling through the idling patterns.
    phase = 0;
    while (phase < 4 || requests_sent < 400) begin
      configure(($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4),
                ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4),
                $urandom_range(0, 6));
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 54; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 54; end
        default: begin idle_pct = 31; stall_pct = 31; end
      endcase
      load_image();
      n_rounds = $urandom_range(1, 3);
      for (int r = 0; r < n_rounds; r++) begin
        run_relaxation();
        if (phase == 2 && r == 0) begin
          // Long receiver hold-off while reads keep coming.
          idle_pct = 0;
          hold_go = 1'b1;
          read_some(24);
          idle_pct = 54;
          stall_pct = 54;
        end
        read_some($urandom_range(img_w * img_h, img_w * img_h + 4));
        if ($urandom_range(2) == 0) begin
          load_pixel($urandom_range(0, img_w * img_h - 1));
          read_some(3);
        end
        if ($urandom_range(4) == 0) send_noise();
      end
      phase++;
    end

    // Register extremes written with the block idle.
    configure(511, 511, 20'hFFFFF);
    settle();

    if (mismatches == 0) begin
      $display("height_from_gradient_relaxation test passed");
    end else begin
      $display("height_from_gradient_relaxation test failed");
    end
    $finish;
  end

endmodule
